// File: rtl/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

	// Table size and derived widths
	localparam int MAX_PROCS = 16;
	localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);
	localparam int TIME_W    = 24;
	localparam int SUM_W     = 32;
	localparam int TIDX_W    = 4;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

	// Command codes
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// One table entry as stored in the task memory
	typedef struct packed {
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
		logic [7:0]  prio;
	} task_entry_t;

	// Write-side control of the task table
	typedef struct packed {
		logic              en;        // write entry, clear its done flag
		logic [IDX_W-1:0]  addr;
		task_entry_t       data;
		logic              set_done;  // mark entry at addr complete
		logic              clr_all;   // drop every done flag
	} tbl_wr_t;

	// Saturating accumulate
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
		input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
	endfunction

	// Low bits of a table index as reported on the result port
	function automatic logic [TIDX_W-1:0] port_index(input logic [IDX_W-1:0] idx);
		logic [IDX_W+TIDX_W-1:0] w;
		w = (IDX_W + TIDX_W)'(idx);
		return w[TIDX_W-1:0];
	endfunction

endpackage

// File: rtl/preemptive_priority_scheduler_unit.sv
`timescale 1ns / 1ps
// Clear, load and the unused command go from accept to the emit state and then to the result register.
// A tick scans the task memory one entry per cycle, then updates the chosen entry;
// when a task completes, the turnaround, waiting and sum states follow before the emit state.
// One command at a time; a new one is taken while the last result waits.
// Reset (async, active low) empties the table and zeroes time and totals.
module preemptive_priority_scheduler_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [1:0]                     mode,
	input  logic [15:0]                    arrival,
	input  logic [15:0]                    burst,
	input  logic [7:0]                     priority_req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic                           status,
	output logic                           ran,
	output logic [pps_pkg::TIDX_W-1:0]     task_index,
	output logic                           finished,
	output logic [pps_pkg::TIME_W-1:0]     finish_time,
	output logic [pps_pkg::TIME_W-1:0]     turnaround,
	output logic [pps_pkg::TIME_W-1:0]     waiting,
	output logic                           all_done,
	output logic [pps_pkg::SUM_W-1:0]      total_turnaround,
	output logic [pps_pkg::SUM_W-1:0]      total_waiting,
	output logic [pps_pkg::TIME_W-1:0]     now_time
);
	import pps_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_UPD  = 3'd2;
	localparam logic [2:0] S_TAT  = 3'd3;
	localparam logic [2:0] S_WT   = 3'd4;
	localparam logic [2:0] S_SUMW = 3'd5;
	localparam logic [2:0] S_EMIT = 3'd6;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  entry_cnt_q;
	logic [CNT_W-1:0]  done_cnt_q;
	logic [TIME_W-1:0] time_q;
	logic [SUM_W-1:0]  sum_tat_q;
	logic [SUM_W-1:0]  sum_wt_q;

	// Scan pipeline
	logic [CNT_W-1:0]  scan_cnt_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  pidx_s1;

	// Best candidate so far
	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	task_entry_t       best_q;

	// Per-command result
	logic              res_status_q;
	logic              res_ran_q;
	logic [TIDX_W-1:0] res_idx_q;
	logic              res_fin_q;
	logic [TIME_W-1:0] res_ftime_q;
	logic [TIME_W-1:0] res_tat_q;
	logic [TIME_W-1:0] res_wt_q;

	// Output register
	logic              rsp_valid_q;
	logic              status_q;
	logic              ran_q;
	logic [TIDX_W-1:0] task_index_q;
	logic              finished_q;
	logic [TIME_W-1:0] finish_time_q;
	logic [TIME_W-1:0] turnaround_q;
	logic [TIME_W-1:0] waiting_q;
	logic              all_done_q;
	logic [SUM_W-1:0]  tot_turn_q;
	logic [SUM_W-1:0]  total_wt_q;
	logic [TIME_W-1:0] now_time_q;

	tbl_wr_t           tbl_wr;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	task_entry_t       rd_entry;
	logic              rd_done;

	logic              req_acc;
	logic              tbl_full;
	logic              scan_issue;
	logic              cand_ok;
	logic              cand_better;
	logic [15:0]       rem_dec;
	logic [TIME_W-1:0] time_next;
	logic              emit_go;

	pps_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.rd_done  (rd_done)
	);

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && (state_q == S_IDLE);
	assign tbl_full  = (entry_cnt_q >= CNT_W'(MAX_PROCS));

	// Scan: issue one read per cycle, judge the entry in the cycle after its read
	assign scan_issue = (state_q == S_SCAN) && (scan_cnt_q < entry_cnt_q);
	assign rd_en      = scan_issue;
	assign rd_addr    = scan_cnt_q[IDX_W-1:0];

	assign cand_ok = pend_s1 && !rd_done &&
		(TIME_W'(rd_entry.arrival) <= time_q);
	assign cand_better = !found_q || (rd_entry.prio < best_q.prio) ||
		((rd_entry.prio == best_q.prio) && (rd_entry.arrival < best_q.arrival));

	assign rem_dec   = best_q.remaining - 16'd1;
	assign time_next = (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);

	// Table writes: clear and load at accept, remaining-count write-back after the scan.
	// Scan reads and the write-back never overlap since commands are serialized.
	always_comb begin
		tbl_wr          = '0;
		tbl_wr.addr     = entry_cnt_q[IDX_W-1:0];
		tbl_wr.data.arrival   = arrival;
		tbl_wr.data.burst     = (burst == 16'd0) ? 16'd1 : burst;
		tbl_wr.data.remaining = (burst == 16'd0) ? 16'd1 : burst;
		tbl_wr.data.prio      = priority_req;
		if (req_acc && (mode == MODE_CLEAR)) begin
			tbl_wr.clr_all = 1'b1;
		end else if (req_acc && (mode == MODE_LOAD) && !tbl_full) begin
			tbl_wr.en = 1'b1;
		end else if ((state_q == S_UPD) && found_q) begin
			tbl_wr.addr           = best_idx_q;
			tbl_wr.data           = best_q;
			tbl_wr.data.remaining = rem_dec;
			tbl_wr.en             = 1'b1;
			tbl_wr.set_done       = (rem_dec == 16'd0);
		end
	end

	// Best entry with the decremented count, stored back into best_q (the table's en path clears done unless set_done)
	task_entry_t upd_data;
	assign upd_data = '{arrival: best_q.arrival, burst: best_q.burst,
		remaining: rem_dec, prio: best_q.prio};

	assign emit_go = (state_q == S_EMIT) && (!rsp_valid_q || !rsp_stall);

	// Command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			entry_cnt_q  <= '0;
			done_cnt_q   <= '0;
			time_q       <= '0;
			sum_tat_q    <= '0;
			sum_wt_q     <= '0;
			scan_cnt_q   <= '0;
			pend_s1      <= 1'b0;
			pidx_s1      <= '0;
			found_q      <= 1'b0;
			best_idx_q   <= '0;
			best_q       <= '0;
			res_status_q <= 1'b0;
			res_ran_q    <= 1'b0;
			res_idx_q    <= '0;
			res_fin_q    <= 1'b0;
			res_ftime_q  <= '0;
			res_tat_q    <= '0;
			res_wt_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						res_status_q <= 1'b0;
						res_ran_q    <= 1'b0;
						res_idx_q    <= '0;
						res_fin_q    <= 1'b0;
						res_ftime_q  <= '0;
						res_tat_q    <= '0;
						res_wt_q     <= '0;
						scan_cnt_q   <= '0;
						pend_s1      <= 1'b0;
						found_q      <= 1'b0;
						state_q      <= S_EMIT;
						case (mode)
							MODE_CLEAR: begin
								entry_cnt_q <= '0;
								done_cnt_q  <= '0;
								time_q      <= '0;
								sum_tat_q   <= '0;
								sum_wt_q    <= '0;
							end
							MODE_LOAD: begin
								if (tbl_full) begin
									res_status_q <= 1'b1;
								end else begin
									entry_cnt_q <= entry_cnt_q + CNT_W'(1);
								end
							end
							MODE_TICK: begin
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_SCAN: begin
					pend_s1 <= scan_issue;
					pidx_s1 <= rd_addr;
					if (scan_issue) begin
						scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					end
					if (cand_ok && cand_better) begin
						found_q    <= 1'b1;
						best_idx_q <= pidx_s1;
						best_q     <= rd_entry;
					end
					if (!scan_issue && !pend_s1) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					time_q  <= time_next;
					state_q <= S_EMIT;
					if (found_q) begin
						res_ran_q <= 1'b1;
						res_idx_q <= port_index(best_idx_q);
						best_q    <= upd_data;
						if (rem_dec == 16'd0) begin
							res_fin_q   <= 1'b1;
							res_ftime_q <= time_next;
							done_cnt_q  <= done_cnt_q + CNT_W'(1);
							state_q     <= S_TAT;
						end
					end
				end
				S_TAT: begin
					res_tat_q <= res_ftime_q - TIME_W'(best_q.arrival);
					state_q   <= S_WT;
				end
				S_WT: begin
					res_wt_q  <= (res_tat_q >= TIME_W'(best_q.burst)) ?
						res_tat_q - TIME_W'(best_q.burst) : '0;
					sum_tat_q <= sat_add(sum_tat_q, SUM_W'(res_tat_q));
					state_q   <= S_SUMW;
				end
				S_SUMW: begin
					sum_wt_q <= sat_add(sum_wt_q, SUM_W'(res_wt_q));
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register toward the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			status_q      <= res_status_q;
			ran_q         <= res_ran_q;
			task_index_q  <= res_idx_q;
			finished_q    <= res_fin_q;
			finish_time_q <= res_ftime_q;
			turnaround_q  <= res_tat_q;
			waiting_q     <= res_wt_q;
			all_done_q    <= (done_cnt_q == entry_cnt_q);
			tot_turn_q    <= sum_tat_q;
			total_wt_q    <= sum_wt_q;
			now_time_q    <= time_q;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign status           = status_q;
	assign ran              = ran_q;
	assign task_index       = task_index_q;
	assign finished         = finished_q;
	assign finish_time      = finish_time_q;
	assign turnaround       = turnaround_q;
	assign waiting          = waiting_q;
	assign all_done         = all_done_q;
	assign total_turnaround = tot_turn_q;
	assign total_waiting    = total_wt_q;
	assign now_time         = now_time_q;

	// Checks
	a_done_le_entries: assert property (@(posedge clk) disable iff (!arst_n)
		done_cnt_q <= entry_cnt_q)
		else $error("completed count exceeds loaded count");

	a_entries_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= CNT_W'(MAX_PROCS))
		else $error("task table count out of range");

	a_finish_implies_ran: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && finished_q |-> ran_q)
		else $error("completion reported for an idle tick");

	a_writeback_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr.set_done |-> !rd_en && (state_q == S_UPD))
		else $error("table write-back overlaps a scan read");

endmodule

// File: rtl/pps_table.sv
`timescale 1ns / 1ps

module pps_table (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pps_pkg::tbl_wr_t              wr,
	input  logic                          rd_en,
	input  logic [pps_pkg::IDX_W-1:0]     rd_addr,
	output pps_pkg::task_entry_t          rd_entry,
	output logic                          rd_done
);
	import pps_pkg::*;

	task_entry_t           mem [MAX_PROCS];
	logic [MAX_PROCS-1:0]  done_q;
	task_entry_t           rd_entry_q;
	logic                  rd_done_q;

	// Task memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_entry_q <= mem[rd_addr];
		end
	end

	// Completion flags, cleared at reset and by a table clear;
	// a completing write-back sets the flag, any other entry write clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= '0;
			rd_done_q <= 1'b0;
		end else begin
			if (wr.clr_all) begin
				done_q <= '0;
			end else if (wr.set_done) begin
				done_q[wr.addr] <= 1'b1;
			end else if (wr.en) begin
				done_q[wr.addr] <= 1'b0;
			end
			if (rd_en) begin
				rd_done_q <= done_q[rd_addr];
			end
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_done  = rd_done_q;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

	import pps_pkg::*;

	// Opcode 3 has no meaning in the block; it must leave the state alone
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam int TOTAL_ITEMS = 1275;
	localparam int PHASE_LEN   = 430;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 40;
	localparam int NUM_FIELDS  = 11;

	// One result transaction, in port order
	typedef struct packed {
		logic              status;
		logic              ran;
		logic [TIDX_W-1:0] task_idx;
		logic              finished;
		logic [TIME_W-1:0] finish_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic              all_done;
		logic [SUM_W-1:0]  total_turn;
		logic [SUM_W-1:0]  total_wait;
		logic [TIME_W-1:0] now;
	} sched_result_t;

	// Scheduler shadow: task table, clock, totals and the results still owed
	class sched_scoreboard;
		logic [15:0]       t_arrival [MAX_PROCS];
		logic [15:0]       t_burst   [MAX_PROCS];
		logic [15:0]       t_left    [MAX_PROCS];
		logic [7:0]        t_prio    [MAX_PROCS];
		bit                t_done    [MAX_PROCS];
		int                n_entries;
		int                n_done;
		logic [TIME_W-1:0] clock_now;
		logic [SUM_W-1:0]  tat_sum;
		logic [SUM_W-1:0]  wait_sum;
		sched_result_t     outcome_q[$];
		int                errors;
		int                n_cmds, n_loads, n_refused, n_ticks, n_idle_ticks;
		int                n_completed, n_checked;

		function new();
			clear_table();
		endfunction

		function void clear_table();
			foreach (t_done[i])
				t_done[i] = 1'b0;
			n_entries = 0;
			n_done    = 0;
			clock_now = '0;
			tat_sum   = '0;
			wait_sum  = '0;
		endfunction

		function logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
			logic [SUM_W:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
		endfunction

		// Applies one command to the shadow table and returns its result
		function sched_result_t schedule_step(logic [1:0] m, logic [15:0] a,
			logic [15:0] b, logic [7:0] p);
			sched_result_t     r;
			int                best;
			bit                found;
			logic [TIME_W-1:0] tat;
			logic [TIME_W-1:0] wt;
			r     = '0;
			best  = 0;
			found = 1'b0;
			case (m)
				MODE_CLEAR: clear_table();
				MODE_LOAD: begin
					if (n_entries >= MAX_PROCS) begin
						r.status = 1'b1;
						n_refused++;
					end else begin
						t_arrival[n_entries] = a;
						t_burst[n_entries]   = (b == 16'd0) ? 16'd1 : b;
						t_left[n_entries]    = t_burst[n_entries];
						t_prio[n_entries]    = p;
						t_done[n_entries]    = 1'b0;
						n_entries++;
					end
				end
				MODE_TICK: begin
					// lowest priority value, then earliest arrival, then lowest index
					for (int i = 0; i < n_entries; i++) begin
						if (!t_done[i] && TIME_W'(t_arrival[i]) <= clock_now) begin
							if (!found || t_prio[i] < t_prio[best] ||
								(t_prio[i] == t_prio[best] &&
								t_arrival[i] < t_arrival[best])) begin
								best  = i;
								found = 1'b1;
							end
						end
					end
					if (clock_now != TIME_MAX)
						clock_now = clock_now + TIME_W'(1);
					if (found) begin
						r.ran      = 1'b1;
						r.task_idx = best[TIDX_W-1:0];
						if (t_left[best] != 16'd0)
							t_left[best] = t_left[best] - 16'd1;
						if (t_left[best] == 16'd0) begin
							tat           = clock_now - TIME_W'(t_arrival[best]);
							wt            = (tat >= TIME_W'(t_burst[best])) ?
								tat - TIME_W'(t_burst[best]) : '0;
							r.finished    = 1'b1;
							r.finish_time = clock_now;
							r.turnaround  = tat;
							r.waiting     = wt;
							tat_sum       = sum_sat(tat_sum, SUM_W'(tat));
							wait_sum      = sum_sat(wait_sum, SUM_W'(wt));
							t_done[best]  = 1'b1;
							n_done++;
							n_completed++;
						end
					end else begin
						n_idle_ticks++;
					end
				end
				default: ;
			endcase
			r.all_done   = (n_done == n_entries);
			r.total_turn = tat_sum;
			r.total_wait = wait_sum;
			r.now        = clock_now;
			return r;
		endfunction

		// Accepted command transaction
		function void note_command(logic [1:0] m, logic [15:0] a, logic [15:0] b,
			logic [7:0] p);
			n_cmds++;
			if (m == MODE_LOAD)
				n_loads++;
			if (m == MODE_TICK)
				n_ticks++;
			outcome_q.push_back(schedule_step(m, a, b, p));
		endfunction

		function logic [31:0] field_val(sched_result_t r, int k);
			case (k)
				0:       return 32'(r.status);
				1:       return 32'(r.ran);
				2:       return 32'(r.task_idx);
				3:       return 32'(r.finished);
				4:       return 32'(r.finish_time);
				5:       return 32'(r.turnaround);
				6:       return 32'(r.waiting);
				7:       return 32'(r.all_done);
				8:       return r.total_turn;
				9:       return r.total_wait;
				default: return 32'(r.now);
			endcase
		endfunction

		function string field_name(int k);
			case (k)
				0:       return "status";
				1:       return "ran";
				2:       return "task_index";
				3:       return "finished";
				4:       return "finish_time";
				5:       return "turnaround";
				6:       return "waiting";
				7:       return "all_done";
				8:       return "total_turnaround";
				9:       return "total_waiting";
				default: return "now_time";
			endcase
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("[%0t] ERROR: %s", $realtime, msg);
		endfunction

		// Accepted result transaction against the oldest one owed
		function void check_result(sched_result_t got);
			sched_result_t exp;
			if (outcome_q.size() == 0) begin
				report("result arrived with no command outstanding");
				return;
			end
			exp = outcome_q.pop_front();
			n_checked++;
			for (int k = 0; k < NUM_FIELDS; k++) begin
				if (field_val(got, k) !== field_val(exp, k))
					report($sformatf("result %0d, %s: expected 0x%0h, got 0x%0h",
						n_checked, field_name(k), field_val(exp, k), field_val(got, k)));
			end
		endfunction
	endclass

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 req_valid    = 1'b0;
	logic                 req_stall;
	logic [1:0]           mode         = MODE_CLEAR;
	logic [15:0]          arrival      = '0;
	logic [15:0]          burst        = '0;
	logic [7:0]           priority_req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall    = 1'b0;
	logic                 status;
	logic                 ran;
	logic [TIDX_W-1:0]    task_index;
	logic                 finished;
	logic [TIME_W-1:0]    finish_time;
	logic [TIME_W-1:0]    turnaround;
	logic [TIME_W-1:0]    waiting;
	logic                 all_done;
	logic [SUM_W-1:0]     total_turnaround;
	logic [SUM_W-1:0]     total_waiting;
	logic [TIME_W-1:0]    now_time;

	sched_scoreboard sb = new();
	int              send_idle_pct = 24;
	int              rsp_idle_pct  = 46;
	int              items_sent    = 0;
	int              gen_time      = 0;
	int              cycle_cnt     = 0;

	preemptive_priority_scheduler_unit u_dut (.*);

	always #5 clk = ~clk;

	// Receiver back-pressure
	always @(posedge clk)
		rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);

	// Watch both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_command(mode, arrival, burst, priority_req);
			if (rsp_valid && !rsp_stall)
				sb.check_result('{status, ran, task_index, finished, finish_time, turnaround,
					waiting, all_done, total_turnaround, total_waiting, now_time});
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("watchdog expired after %0d cycles", cycle_cnt);
			$display("preemptive_priority_scheduler_unit regression: fail");
			$finish;
		end
	end

	// One command transaction, with a random gap ahead of it
	task automatic send_cmd(logic [1:0] m, logic [15:0] a, logic [15:0] b, logic [7:0] p);
		if (items_sent < PHASE_LEN) begin
			send_idle_pct = 24;
			rsp_idle_pct  = 46;
		end else if (items_sent < 2 * PHASE_LEN) begin
			send_idle_pct = 46;
			rsp_idle_pct  = 24;
		end else begin
			send_idle_pct = 0;
			rsp_idle_pct  = 0;
		end
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid    <= 1'b1;
		mode         <= m;
		arrival      <= a;
		burst        <= b;
		priority_req <= p;
		do
			@(posedge clk);
		while (req_stall);
		items_sent++;
		if (m == MODE_CLEAR)
			gen_time = 0;
		else if (m == MODE_TICK)
			gen_time++;
	endtask

	task automatic send_noise();
		send_cmd(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom), 8'($urandom));
	endtask

	// Load a task arriving near the current time, mostly short and with close priorities
	task automatic send_load(inout int work);
		int          sel;
		logic [15:0] a;
		logic [15:0] b;
		logic [7:0]  p;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			a = 16'($urandom);
		else if (sel == 1)
			a = '0;
		else
			a = 16'((gen_time + $urandom_range(0, 10) > 65535) ? 65535 :
				gen_time + $urandom_range(0, 10));
		sel = $urandom_range(0, 19);
		if (sel == 0)
			b = '0;
		else if (sel == 1)
			b = 16'($urandom);
		else if (sel == 2)
			b = 16'($urandom_range(7, 40));
		else
			b = 16'($urandom_range(1, 6));
		if (b <= 16'd40)
			work += (b == 16'd0) ? 1 : int'(b);
		p = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		send_cmd(MODE_LOAD, a, b, p);
	endtask

	// Clear (most of the time), fill, then tick through it with late loads and a little noise
	task automatic run_episode();
		int n;
		int work;
		int ticks;
		int sel;
		work = 0;
		if ($urandom_range(0, 99) < 80)
			send_cmd(MODE_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom));
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			send_load(work);
		ticks = (work + 10 > 120) ? 120 : work + 10;
		for (int i = 0; i < ticks; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 8)
				send_load(work);
			else if (sel < 11)
				send_noise();
			else
				send_cmd(MODE_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every opcode, zero and full-scale fields, ties, full table
		send_cmd(MODE_CLEAR, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_cmd(MODE_UNUSED, 16'hA5A5, 16'h5A5A, 8'h3C);
		send_cmd(MODE_LOAD, 16'd0, 16'd0, 8'd0);
		send_cmd(MODE_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_cmd(MODE_LOAD, 16'd1, 16'd2, 8'd0);
		repeat (3)
			send_cmd(MODE_TICK, 16'd0, 16'd0, 8'd0);
		// equal priority and arrival, so the lower index goes first
		repeat (13)
			send_cmd(MODE_LOAD, 16'd3, 16'd1, 8'd7);
		send_cmd(MODE_LOAD, 16'd0, 16'd1, 8'd0);
		repeat (2)
			send_cmd(MODE_TICK, 16'hFFFF, 16'hFFFF, 8'hFF);
		send_cmd(MODE_UNUSED, 16'h0000, 16'h0000, 8'h00);

		// Random part
		while (items_sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				send_noise();
			else
				run_episode();
		end
		req_valid <= 1'b0;

		while (sb.outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sb.outcome_q.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.outcome_q.size()));
		$display("%0d commands: %0d loads (%0d refused on a full table), %0d ticks (%0d idle)",
			sb.n_cmds, sb.n_loads, sb.n_refused, sb.n_ticks, sb.n_idle_ticks);
		$display("%0d task completions, %0d results compared, %0d errors",
			sb.n_completed, sb.n_checked, sb.errors);
		if (sb.errors == 0)
			$display("preemptive_priority_scheduler_unit regression: pass");
		else
			$display("preemptive_priority_scheduler_unit regression: fail");
		$finish;
	end

endmodule
